@@ rtl/blecw_pkg.sv @@
// ----------------------------------------------------------------------------
// blecw_pkg
// Shared types, constants and bit-level functions for the CRC and whitening
// encoder: CRC byte update, whitening mask generation and wire bit reversal.
// ----------------------------------------------------------------------------
package blecw_pkg;

  localparam logic [23:0] CRC_INIT      = 24'hAAAAAA;
  localparam logic [7:0]  CRC_TAP_LOW   = 8'hDA;
  localparam logic [7:0]  CRC_TAP_MID   = 8'h60;
  localparam logic [7:0]  LFSR_TAP      = 8'h88;
  localparam logic [6:0]  LFSR_SEED_BIT = 7'h40;
  localparam logic [5:0]  CHANNEL_RESET = 6'd37;
  localparam int          CRC_BYTES     = 3;

  typedef struct packed {
    logic [7:0]  wire_byte;
    logic        last;
    logic [23:0] crc;
    logic [6:0]  lfsr;
  } blecw_entry_t;

  typedef struct packed {
    logic [7:0] mask;
    logic [6:0] lfsr;
  } blecw_white_t;

  function automatic logic [7:0] reverse8(input logic [7:0] a);
    logic [7:0] v;
    for (int k = 0; k < 8; k++) begin
      v[7-k] = a[k];
    end
    return v;
  endfunction

  // register held as {lo, mid, hi}: one right shift moves every byte chain
  function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] d);
    logic [23:0] t;
    logic        out;
    t = {crc[7:0], crc[15:8], crc[23:16]};
    for (int k = 0; k < 8; k++) begin
      out = t[0];
      t = t >> 1;
      if (out != d[k]) begin
        t = t ^ {CRC_TAP_LOW, CRC_TAP_MID, 8'h00};
      end
    end
    return {t[7:0], t[15:8], t[23:16]};
  endfunction

  function automatic blecw_white_t whiten(input logic [6:0] seed);
    logic [7:0]   l;
    blecw_white_t r;
    l = {1'b0, seed};
    r.mask = '0;
    for (int k = 0; k < 8; k++) begin
      if (l[0]) begin
        l = l ^ LFSR_TAP;
        r.mask[k] = 1'b1;
      end
      l = l >> 1;
    end
    r.lfsr = l[6:0];
    return r;
  endfunction

endpackage

@@ rtl/ble_packet_crc_whiten_encoder.sv @@
// ----------------------------------------------------------------------------
// ble_packet_crc_whiten_encoder
// Low-energy radio link-layer encoder: CRC-24 and data whitening per packet.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle while in_ready is high and emits each byte
// whitened and in wire bit order; after a byte marked is_last it appends the
// three whitened CRC bytes, the final one flagged end_of_packet. The single
// output register sends the CRC bytes one per cycle while out_ready is high.
// The front updates CRC and LFSR state for each byte and buffers up to
// QUEUE_DEPTH bytes, so input keeps flowing while CRC bytes drain. The channel
// written on the cfg port seeds the whitening at the start of the next packet;
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module ble_packet_crc_whiten_encoder
  import blecw_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] wire_byte,
  output logic       end_of_packet
);

  logic [5:0]   channel;
  logic         q_full;
  logic         q_empty;
  logic         q_push;
  logic         q_pop;
  blecw_entry_t q_entry;
  blecw_entry_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel <= CHANNEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      channel <= cfg_data;
    end
  end

  blecw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .channel   (channel),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .is_last   (is_last),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  blecw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  blecw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .wire_byte     (wire_byte),
    .end_of_packet (end_of_packet)
  );

endmodule

@@ rtl/blecw_front.sv @@
// ----------------------------------------------------------------------------
// blecw_front
// Accepts packet bytes, updates the CRC and whitening state, and queues each
// encoded byte with the CRC and LFSR state needed to finish the packet.
// ----------------------------------------------------------------------------
module blecw_front
  import blecw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic [5:0]   channel,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   data_byte,
  input  logic         is_last,
  input  logic         q_full,
  output logic         q_push,
  output blecw_entry_t q_entry
);

  logic [23:0]  crc;
  logic [6:0]   lfsr;
  logic         packet_start;
  logic [23:0]  crc_base;
  logic [6:0]   lfsr_base;
  logic [23:0]  crc_next;
  blecw_white_t wh;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    crc_base  = packet_start ? CRC_INIT : crc;
    lfsr_base = packet_start ? (LFSR_SEED_BIT | {1'b0, channel}) : lfsr;
    crc_next  = crc_feed(crc_base, data_byte);
    wh        = whiten(lfsr_base);
    q_entry.wire_byte = reverse8(data_byte ^ wh.mask);
    q_entry.last      = is_last;
    q_entry.crc       = crc_next;
    q_entry.lfsr      = wh.lfsr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_start <= 1'b1;
      crc          <= CRC_INIT;
      lfsr         <= '0;
    end else if (q_push) begin
      packet_start <= is_last;
      crc          <= crc_next;
      lfsr         <= wh.lfsr;
    end
  end

endmodule

@@ rtl/blecw_fifo.sv @@
// ----------------------------------------------------------------------------
// blecw_fifo
// Short queue of encoded entries between the front and the back.
// ----------------------------------------------------------------------------
module blecw_fifo
  import blecw_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  blecw_entry_t push_entry,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output blecw_entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  blecw_entry_t   slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/blecw_back.sv @@
// ----------------------------------------------------------------------------
// blecw_back
// Drains queued entries into the output register and appends the three
// whitened CRC bytes after the last byte of each packet.
// ----------------------------------------------------------------------------
module blecw_back
  import blecw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_empty,
  input  blecw_entry_t q_head,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   wire_byte,
  output logic         end_of_packet
);

  localparam int NW = $clog2(CRC_BYTES + 1);

  logic [NW-1:0] crc_left;
  logic [23:0]   crc;
  logic [6:0]    lfsr;
  logic          load;
  blecw_white_t  wh;

  assign load  = !out_valid || out_ready;
  assign q_pop = load && (crc_left == '0) && !q_empty;
  assign wh    = whiten(lfsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      crc_left  <= '0;
    end else if (load) begin
      if (crc_left != '0) begin
        out_valid <= 1'b1;
        crc_left  <= crc_left - 1'b1;
      end else if (!q_empty) begin
        out_valid <= 1'b1;
        crc_left  <= q_head.last ? NW'(CRC_BYTES) : '0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (crc_left != '0) begin
        wire_byte     <= reverse8(crc[23:16] ^ wh.mask);
        end_of_packet <= (crc_left == NW'(1));
        crc           <= {crc[15:0], 8'h00};
        lfsr          <= wh.lfsr;
      end else if (!q_empty) begin
        wire_byte     <= q_head.wire_byte;
        end_of_packet <= 1'b0;
        crc           <= q_head.crc;
        lfsr          <= q_head.lfsr;
      end
    end
  end

endmodule
